// ----- rtl/turing_machine_step_engine_defines.svh -----
// ----------------------------------------------------------------------------
// Turing machine step engine assertion macros
// Shared assertion forms for the step engine RTL.
// ----------------------------------------------------------------------------
`ifndef TURING_MACHINE_STEP_ENGINE_DEFINES_SVH
`define TURING_MACHINE_STEP_ENGINE_DEFINES_SVH

// implication checked on every edge outside reset
`define TMS_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define TMS_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- rtl/tms_pkg.sv -----
// ----------------------------------------------------------------------------
// Turing machine step engine package
// Opcodes, status codes, move codes, register indexes, rule and hit records.
// ----------------------------------------------------------------------------
package tms_pkg;
  localparam int NUM_RULES_DEF  = 32;
  localparam int NUM_STATES_DEF = 16;
  localparam int TAPE_DEPTH_DEF = 4096;

  localparam logic [2:0] OP_LOAD   = 3'd0;
  localparam logic [2:0] OP_CLEAR  = 3'd1;
  localparam logic [2:0] OP_APPEND = 3'd2;
  localparam logic [2:0] OP_BEGIN  = 3'd3;
  localparam logic [2:0] OP_STEP   = 3'd4;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_RUNNING = 3'd1;
  localparam logic [2:0] ST_HALTED  = 3'd2;
  localparam logic [2:0] ST_NO_RULE = 3'd3;
  localparam logic [2:0] ST_FULL    = 3'd4;
  localparam logic [2:0] ST_BAD     = 3'd5;

  localparam logic [1:0] MV_STAY  = 2'd0;
  localparam logic [1:0] MV_LEFT  = 2'd1;
  localparam logic [1:0] MV_RIGHT = 2'd2;

  localparam logic [1:0] REG_START = 2'd0;
  localparam logic [1:0] REG_FINAL = 2'd1;
  localparam logic [1:0] REG_COUNT = 2'd2;
  localparam logic [1:0] REG_BLANK = 2'd3;

  typedef struct packed {
    logic [3:0] st;
    logic [7:0] sym;
    logic [3:0] nst;
    logic [7:0] wsym;
    logic [1:0] mv;
  } rule_t;

  // search token travelling down the cell chain
  typedef struct packed {
    logic       found;
    rule_t      rule;
  } hit_t;
endpackage

// ----- rtl/tms_rule_cell.sv -----
// ----------------------------------------------------------------------------
// Rule cell
// Holds one rule; passes the first match of the search key to its neighbor.
// ----------------------------------------------------------------------------
module tms_rule_cell (
  input  logic           clk,
  input  logic           wr_en,
  input  tms_pkg::rule_t wr_rule,
  input  logic           active,
  input  logic [3:0]     key_state,
  input  logic [7:0]     key_sym,
  input  tms_pkg::hit_t  hit_in,
  output tms_pkg::hit_t  hit_out
);
  import tms_pkg::*;

  rule_t rule_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      rule_r <= wr_rule;
    end
  end

  always_comb begin
    hit_out = hit_in;
    if (!hit_in.found && active && rule_r.st == key_state && rule_r.sym == key_sym) begin
      hit_out.found = 1'b1;
      hit_out.rule  = rule_r;
    end
  end
endmodule

// ----- rtl/tms_rule_chain.sv -----
// ----------------------------------------------------------------------------
// Rule chain
// Row of rule cells searched in priority order, registered at the chain end.
// ----------------------------------------------------------------------------
module tms_rule_chain #(
  parameter int NUM_RULES = tms_pkg::NUM_RULES_DEF,
  parameter int IW = (NUM_RULES > 1) ? $clog2(NUM_RULES) : 1
) (
  input  logic           clk,
  input  logic           wr_en,
  input  logic [7:0]     wr_idx,
  input  tms_pkg::rule_t wr_rule,
  input  logic [5:0]     rule_count,
  input  logic [3:0]     key_state,
  input  logic [7:0]     key_sym,
  output tms_pkg::hit_t  hit
);
  import tms_pkg::*;

  hit_t chain [NUM_RULES+1];
  hit_t hit_r;

  assign chain[0] = '0;

  for (genvar g = 0; g < NUM_RULES; g++) begin : g_cell
    tms_rule_cell u_cell (
      .clk       (clk),
      .wr_en     (wr_en && wr_idx == 8'(g)),
      .wr_rule   (wr_rule),
      .active    (7'(g) < {1'b0, rule_count}),
      .key_state (key_state),
      .key_sym   (key_sym),
      .hit_in    (chain[g]),
      .hit_out   (chain[g+1])
    );
  end

  always_ff @(posedge clk) begin
    hit_r <= chain[NUM_RULES];
  end

  assign hit = hit_r;
  logic unused_iw;
  assign unused_iw = IW[0];
endmodule

// ----- rtl/turing_machine_step_engine.sv -----
// ----------------------------------------------------------------------------
// Turing machine step engine
// Rule cell chain with a ring-buffer tape memory and a step sequencer.
// ----------------------------------------------------------------------------
//  channel | dir | handshake          | payload
//  in_     | in  | in_valid/in_stall  | opcode and rule/tape fields
//  out_    | out | out_valid/out_stall| status, state, head, length
//  cfg_    | in  | cfg_valid/cfg_ready| cfg_index, cfg_data
// After acceptance a step goes through tape read, registered rule search,
// write/update and result load; other requests and refused steps go only
// through read and result load. The result shows the cycle after the load;
// the next request is taken the cycle after the result leaves. Each step
// depends on the previous one. Reset is synchronous; no clearing pass. A result
// waits in the output register under out_stall and holds off the input.
module turing_machine_step_engine #(
  parameter int NUM_RULES  = tms_pkg::NUM_RULES_DEF,
  parameter int NUM_STATES = tms_pkg::NUM_STATES_DEF,
  parameter int TAPE_DEPTH = tms_pkg::TAPE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_opcode,
  input  logic [4:0]  in_rule_index,
  input  logic [3:0]  in_match_state,
  input  logic [7:0]  in_match_symbol,
  input  logic [3:0]  in_next_state,
  input  logic [7:0]  in_write_symbol,
  input  logic [1:0]  in_move,
  input  logic [11:0] in_head_position,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [3:0]  out_current_state,
  output logic [11:0] out_head_now,
  output logic [12:0] out_tape_length_now,
  output logic [7:0]  out_symbol_written,
  output logic [1:0]  out_move_done,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import tms_pkg::*;
  `include "turing_machine_step_engine_defines.svh"

  localparam int AW = $clog2(TAPE_DEPTH);
  localparam int LW = AW + 1;

  typedef enum logic [2:0] {S_IDLE, S_READ, S_SEARCH, S_EXEC, S_OUT} state_t;

  state_t     state_r;
  logic [3:0] start_r, mstate_r;
  logic [15:0] final_r;
  logic [5:0] count_r;
  logic [7:0] blank_r;
  logic [AW-1:0] origin_r, head_r;
  logic [LW-1:0] len_r;
  logic [2:0] op_r;
  logic [11:0] hp_r;
  logic [7:0] app_r;
  logic [7:0] mem [TAPE_DEPTH];
  logic [7:0] rd_r;
  logic       we;
  logic [AW-1:0] wa;
  logic [7:0] wd;
  logic       ext_nxt;
  logic [AW-1:0] ext_a_r;
  logic       ext_r;
  hit_t       hit;
  logic [5:0] cnt_lim;
  logic       at_left, at_right, ext_blk;
  logic [1:0] mv_eff;

  assign cnt_lim = (32'(count_r) > NUM_RULES) ? 6'(NUM_RULES) : count_r;
  assign in_stall  = state_r != S_IDLE || out_valid;
  assign cfg_ready = 1'b1;

  tms_rule_chain #(.NUM_RULES(NUM_RULES)) u_chain (
    .clk        (clk),
    .wr_en      (in_valid && !in_stall && in_opcode == OP_LOAD),
    .wr_idx     ({3'b0, in_rule_index}),
    .wr_rule    ({in_match_state, in_match_symbol, in_next_state, in_write_symbol, in_move}),
    .rule_count (cnt_lim),
    .key_state  (mstate_r),
    .key_sym    (rd_r),
    .hit        (hit)
  );

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_r <= mem[AW'(origin_r + head_r)];
  end

  function automatic logic is_final(logic [3:0] s, logic [15:0] m);
    return (32'(s) < NUM_STATES) && m[s];
  endfunction

  always_comb begin
    at_left  = hit.rule.mv == MV_LEFT && head_r == '0;
    at_right = hit.rule.mv == MV_RIGHT && LW'(head_r) + 1'b1 == len_r;
    ext_blk  = (at_left || at_right) && 32'(len_r) >= TAPE_DEPTH;
    ext_nxt  = state_r == S_EXEC && hit.found && (at_left || at_right) && !ext_blk;
    mv_eff   = (hit.rule.mv == MV_LEFT || hit.rule.mv == MV_RIGHT) ? hit.rule.mv : MV_STAY;
  end

  always_comb begin
    we = 1'b0; wa = ext_a_r; wd = blank_r;
    if (ext_r) begin
      we = 1'b1;
    end else if (state_r == S_READ && op_r == OP_APPEND && 32'(len_r) < TAPE_DEPTH) begin
      we = 1'b1; wa = AW'(origin_r + AW'(len_r)); wd = app_r;
    end else if (state_r == S_EXEC && hit.found) begin
      we = 1'b1; wa = AW'(origin_r + head_r); wd = hit.rule.wsym;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; out_valid <= 1'b0;
      start_r <= '0; final_r <= '0; count_r <= '0; blank_r <= 8'd48;
      origin_r <= '0; head_r <= '0; len_r <= '0; mstate_r <= '0; ext_r <= 1'b0;
    end else begin
      ext_r <= ext_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_START: start_r <= cfg_data[3:0];
          REG_FINAL: final_r <= cfg_data;
          REG_COUNT: count_r <= cfg_data[5:0];
          REG_BLANK: blank_r <= cfg_data[7:0];
          default: ;
        endcase
      end
      if (state_r == S_OUT) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: if (in_valid && !in_stall) begin
          op_r <= in_opcode; hp_r <= in_head_position; app_r <= in_write_symbol;
          state_r <= S_READ;
        end
        S_READ: begin
          out_symbol_written <= '0; out_move_done <= MV_STAY;
          unique case (op_r)
            OP_CLEAR: begin
              len_r <= '0; origin_r <= '0; head_r <= '0;
              out_status <= ST_OK; state_r <= S_OUT;
            end
            OP_APPEND: begin
              state_r <= S_OUT;
              if (32'(len_r) < TAPE_DEPTH) begin
                len_r <= len_r + 1'b1; out_status <= ST_OK;
              end else out_status <= ST_FULL;
            end
            OP_BEGIN: begin
              state_r <= S_OUT;
              if (32'(hp_r) < 32'(len_r)) begin
                head_r <= AW'(hp_r); mstate_r <= start_r; out_status <= ST_OK;
              end else out_status <= ST_BAD;
            end
            OP_STEP: if (len_r == '0 || LW'(head_r) >= len_r) begin
                out_status <= ST_BAD; state_r <= S_OUT;
              end else state_r <= S_SEARCH;
            default: begin
              out_status <= ST_OK; state_r <= S_OUT;
            end
          endcase
        end
        S_SEARCH: state_r <= S_EXEC;
        S_EXEC: begin
          state_r <= S_OUT;
          if (!hit.found) begin
            out_status <= ST_NO_RULE;
          end else begin
            mstate_r <= hit.rule.nst;
            out_symbol_written <= hit.rule.wsym;
            if (ext_blk) begin
              out_status <= ST_FULL;
            end else begin
              out_status <= is_final(hit.rule.nst, final_r) ? ST_HALTED : ST_RUNNING;
              out_move_done <= mv_eff;
              if (at_left) begin
                origin_r <= origin_r - 1'b1; ext_a_r <= origin_r - 1'b1;
                len_r <= len_r + 1'b1;
              end else if (hit.rule.mv == MV_LEFT) begin
                head_r <= head_r - 1'b1;
              end else if (hit.rule.mv == MV_RIGHT) begin
                if (at_right) begin
                  ext_a_r <= AW'(origin_r + AW'(len_r)); len_r <= len_r + 1'b1;
                end
                head_r <= head_r + 1'b1;
              end
            end
          end
        end
        S_OUT: begin
          state_r <= S_IDLE;
          out_current_state <= mstate_r;
          out_head_now <= 12'(head_r);
          out_tape_length_now <= 13'(len_r);
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `TMS_ASSERT_IMP(a_no_accept_busy, state_r != S_IDLE, in_stall)
  `TMS_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_status))
  `TMS_ASSERT_IMP(a_len_bound, 1'b1, 32'(len_r) <= TAPE_DEPTH)
  `TMS_ASSERT_IMP(a_ext_after_exec, ext_r, state_r == S_OUT)
endmodule
